// ===== sv/hnm_pkg.sv =====
`timescale 1ns / 1ps
package hnm_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;
	localparam cfg_index_t CFG_ROW_WIDTH  = 2'd0;
	localparam cfg_index_t CFG_ROW_COUNT  = 2'd1;
	localparam cfg_index_t CFG_MAX_HEIGHT = 2'd2;

	// register reset values
	localparam logic [10:0] ROW_WIDTH_RST  = 11'd256;
	localparam logic [12:0] ROW_COUNT_RST  = 13'd256;
	localparam logic [7:0]  MAX_HEIGHT_RST = 8'd255;

	// encoded normal (0, 1, 0) used on border pixels
	localparam logic [7:0] CODE_MID = 8'd127;
	localparam logic [7:0] CODE_TOP = 8'd255;

	// 255 squared, scale of the numerator in the code compare
	localparam logic [31:0] SCALE_SQ = 32'd65025;

	typedef struct packed {
		logic              start;
		logic signed [8:0] nx;
		logic signed [8:0] nz;
	} enc_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] z;
	} enc_res_t;

endpackage

// ===== sv/hnm_in_if.sv =====
`timescale 1ns / 1ps
interface hnm_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] raw_height;
	modport source (output valid, output operation, output raw_height, input ready);
	modport sink (input valid, input operation, input raw_height, output ready);
endinterface

// ===== sv/hnm_out_if.sv =====
`timescale 1ns / 1ps
interface hnm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] normal_x;
	logic [7:0] normal_y;
	logic [7:0] normal_z;
	logic       frame_end;
	modport source (output valid, output normal_x, output normal_y, output normal_z,
		output frame_end, input ready);
	modport sink (input valid, input normal_x, input normal_y, input normal_z,
		input frame_end, output ready);
endinterface

// ===== sv/hnm_cfg_if.sv =====
`timescale 1ns / 1ps
interface hnm_cfg_if;
	import hnm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/hnm_ram.sv =====
`timescale 1ns / 1ps
module hnm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/hnm_encode.sv =====
`timescale 1ns / 1ps
module hnm_encode (
	input  logic              clk,
	input  logic              arst_n,
	input  hnm_pkg::enc_req_t req,
	output hnm_pkg::enc_res_t res
);
	import hnm_pkg::*;

	typedef enum logic [5:0] {
		EN_IDLE = 6'b000001,
		EN_SUM  = 6'b000010,
		EN_NSQ  = 6'b000100,
		EN_BSQ  = 6'b001000,
		EN_MUL  = 6'b010000,
		EN_CMP  = 6'b100000
	} enc_state_t;

	enc_state_t        state_q;
	logic signed [8:0] nx_q, nz_q;
	logic [16:0]       s_q;
	logic [1:0]        comp_q;
	logic [15:0]       nsq_q;
	logic [31:0]       bb2_q;
	logic              nneg_q;
	logic [7:0]        lo_q, hi_q, mid_q;
	logic [15:0]       aa2_q;
	logic              apos_q;
	logic [7:0]        code_x_q, code_y_q, code_z_q;
	logic              done_q;

	logic signed [8:0] n_cur;
	logic [7:0]        nabs;
	logic [7:0]        nxa, nza;
	logic [8:0]        mid_w;
	logic [7:0]        mid;
	logic [7:0]        aabs;
	logic [32:0]       prod;
	logic              fits;
	logic [7:0]        lo_n, hi_n;

	// select the numerator of the current component
	always_comb begin
		case (comp_q)
			2'd0:    n_cur = nx_q;
			2'd1:    n_cur = 9'sd2;
			default: n_cur = nz_q;
		endcase
		nabs = n_cur[8] ? 8'(-n_cur) : n_cur[7:0];
		nxa  = nx_q[8] ? 8'(-nx_q) : nx_q[7:0];
		nza  = nz_q[8] ? 8'(-nz_q) : nz_q[7:0];
	end

	// bisection step: candidate code and |2k - 255|
	always_comb begin
		mid_w = ({1'b0, lo_q} + {1'b0, hi_q} + 9'd1) >> 1;
		mid   = mid_w[7:0];
		aabs  = mid[7] ? 8'({mid, 1'b0} - 9'd255) : 8'(9'd255 - {mid, 1'b0});
	end

	// decide (2k - 255) * sqrt(s) <= 255 * n exactly
	always_comb begin
		prod = 33'(aa2_q) * 33'(s_q);
		if (!apos_q && !nneg_q) begin
			fits = 1'b1;
		end else if (apos_q && nneg_q) begin
			fits = 1'b0;
		end else if (apos_q) begin
			fits = prod <= 33'(bb2_q);
		end else begin
			fits = prod >= 33'(bb2_q);
		end
		lo_n = fits ? mid_q : lo_q;
		hi_n = fits ? hi_q : mid_q - 8'd1;
	end

	// sequence three components through one shared compare unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EN_IDLE;
			comp_q  <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				EN_IDLE: begin
					if (req.start) begin
						comp_q  <= 2'd0;
						state_q <= EN_SUM;
					end
				end
				EN_SUM:  state_q <= EN_NSQ;
				EN_NSQ:  state_q <= EN_BSQ;
				EN_BSQ:  state_q <= EN_MUL;
				EN_MUL:  state_q <= EN_CMP;
				EN_CMP: begin
					if (lo_n == hi_n) begin
						if (comp_q == 2'd2) begin
							done_q  <= 1'b1;
							state_q <= EN_IDLE;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= EN_NSQ;
						end
					end else begin
						state_q <= EN_MUL;
					end
				end
				default: state_q <= EN_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			EN_IDLE: begin
				if (req.start) begin
					nx_q <= req.nx;
					nz_q <= req.nz;
				end
			end
			EN_SUM: begin
				s_q <= 17'(16'(nxa * nxa)) + 17'(16'(nza * nza)) + 17'd4;
			end
			EN_NSQ: begin
				nsq_q  <= 16'(nabs * nabs);
				nneg_q <= n_cur[8];
				lo_q   <= 8'd0;
				hi_q   <= 8'd255;
			end
			EN_BSQ: begin
				bb2_q <= 32'(nsq_q) * SCALE_SQ;
			end
			EN_MUL: begin
				aa2_q  <= 16'(aabs * aabs);
				apos_q <= mid[7];
				mid_q  <= mid;
			end
			EN_CMP: begin
				lo_q <= lo_n;
				hi_q <= hi_n;
				if (lo_n == hi_n) begin
					case (comp_q)
						2'd0:    code_x_q <= lo_n;
						2'd1:    code_y_q <= lo_n;
						default: code_z_q <= lo_n;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign res.done = done_q;
	assign res.x    = code_x_q;
	assign res.y    = code_y_q;
	assign res.z    = code_z_q;
endmodule

// ===== sv/height_to_normal_map_top.sv =====
// Height map to normal map, central differences.
// Channels: samples (sink) takes one raster pixel per item, operation 0 with
// a raw height byte, or operation 1 as a drain step. normals (source) gives
// one encoded normal per pixel in raster order, frame_end on the last one.
// cfg (sink) writes row_width, row_count and max_height; always ready. A
// write to row_width or row_count restarts the frame.
// Latency: the result for pixel p leaves on the item that follows sample
// p + row_width; after the last sample, row_width + 1 drain items flush.
// Throughput: one item at a time. An accepted item first reads the line
// memory; the input is free again once a border result is loaded into the
// output register, or straight after the read for an item with no result,
// while an interior pixel first runs the shared code compare unit: a sum
// step, then for each of 3 components two setup steps and 8 bisection steps.
// A drain step during a frame is consumed with no effect.
// Reset clears the position counters, window taps and output valid, and
// restores the registers to 256 x 256 with scale 255; line memory content
// is not cleared, as no result depends on an unwritten entry.
// Stall: a held result stays in the output register; the next item is still
// accepted and waits only when its own result is ready to be loaded.
`timescale 1ns / 1ps
module height_to_normal_map_top #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_ROWS  = 4096
) (
	input logic        clk,
	input logic        arst_n,
	hnm_in_if.sink     samples,
	hnm_out_if.source  normals,
	hnm_cfg_if.sink    cfg
);
	import hnm_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W = $clog2(MAX_ROWS + 2);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_ENC  = 4'b0100,
		ST_HOLD = 4'b1000
	} top_state_t;

	top_state_t      state_q;
	logic [10:0]     row_width_q;
	logic [12:0]     row_count_q;
	logic [7:0]      max_height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [7:0]      win_up_q, win_dn_q, win_mid_q, win_mid2_q;

	logic [7:0]       hgt_s1;
	logic [COL_W-1:0] col_s1;
	logic             active_s1, emit_s1, last_s1, interior_s1;

	logic border_q, last_q;
	logic       out_valid_q;
	logic [7:0] out_x_q, out_y_q, out_z_q;
	logic       out_end_q;

	logic [WW-1:0]    w_cl;
	logic [ROW_W-1:0] l_cl;
	logic             acc, active, ignore, emit, last, interior;
	logic [WW-1:0]    col_inc;
	logic [15:0]      scale_prod;
	logic [16:0]      scale_sum;
	logic [7:0]       hgt;
	logic [15:0]      rdata;
	logic             ram_we;
	logic [7:0]       upv, midv;
	logic signed [8:0] dx, dy;
	enc_req_t         enc_req;
	enc_res_t         enc_res;
	logic             out_load;

	// clamp the frame size
	always_comb begin
		if (row_width_q < 11'd3) begin
			w_cl = WW'(3);
		end else if (int'(row_width_q) > MAX_WIDTH) begin
			w_cl = WW'(MAX_WIDTH);
		end else begin
			w_cl = WW'(row_width_q);
		end
		if (row_count_q < 13'd3) begin
			l_cl = ROW_W'(3);
		end else if (int'(row_count_q) > MAX_ROWS) begin
			l_cl = ROW_W'(MAX_ROWS);
		end else begin
			l_cl = ROW_W'(row_count_q);
		end
	end

	// classify the incoming item by its frame position
	always_comb begin
		acc      = samples.valid && samples.ready;
		active   = row_q < l_cl;
		ignore   = active && samples.operation;
		emit     = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
		last     = (row_q >= l_cl + ROW_W'(1)) && (col_q == '0);
		interior = active && (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
		col_inc  = WW'(col_q) + WW'(1);
	end

	// scale the raw byte: floor(raw * max_height / 255)
	always_comb begin
		scale_prod = samples.raw_height * max_height_q;
		scale_sum  = 17'(scale_prod) + 17'(scale_prod >> 8) + 17'd1;
		hgt        = scale_sum[15:8];
	end

	assign samples.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;

	// configuration and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q  <= ROW_WIDTH_RST;
			row_count_q  <= ROW_COUNT_RST;
			max_height_q <= MAX_HEIGHT_RST;
			col_q        <= '0;
			row_q        <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_ROW_WIDTH: begin
						row_width_q <= cfg.data[10:0];
						col_q       <= '0;
						row_q       <= '0;
					end
					CFG_ROW_COUNT: begin
						row_count_q <= cfg.data;
						col_q       <= '0;
						row_q       <= '0;
					end
					CFG_MAX_HEIGHT: max_height_q <= cfg.data[7:0];
					default: ;
				endcase
			end else if (acc && !ignore) begin
				if (last) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_inc >= w_cl) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_inc[COL_W-1:0];
				end
			end
		end
	end

	// hold the accepted item while the line memory is read
	always_ff @(posedge clk) begin
		if (acc) begin
			hgt_s1      <= hgt;
			col_s1      <= col_q;
			active_s1   <= active;
			emit_s1     <= emit;
			last_s1     <= last;
			interior_s1 <= interior;
		end
	end

	// line memory: older line in the upper byte, newer line in the lower
	hnm_ram #(
		.WIDTH (16),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata ({midv, hgt_s1}),
		.re    (acc && active && !ignore),
		.raddr (col_q),
		.rdata (rdata)
	);

	assign upv    = rdata[15:8];
	assign midv   = rdata[7:0];
	assign ram_we = (state_q == ST_READ) && active_s1;
	assign dx     = $signed({1'b0, midv}) - $signed({1'b0, win_mid2_q});
	assign dy     = $signed({1'b0, win_up_q}) - $signed({1'b0, win_dn_q});

	assign enc_req.start = (state_q == ST_READ) && interior_s1;
	assign enc_req.nx    = -dx;
	assign enc_req.nz    = dy;

	hnm_encode u_encode (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (enc_req),
		.res    (enc_res)
	);

	// advance the window taps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_up_q   <= '0;
			win_dn_q   <= '0;
			win_mid_q  <= '0;
			win_mid2_q <= '0;
		end else if (ram_we) begin
			win_mid2_q <= win_mid_q;
			win_mid_q  <= midv;
			win_up_q   <= upv;
			win_dn_q   <= hgt_s1;
		end
	end

	assign out_load = (state_q == ST_HOLD) && (!out_valid_q || normals.ready);

	// item sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc && !ignore) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (!emit_s1) begin
						state_q <= ST_IDLE;
					end else if (interior_s1) begin
						state_q <= ST_ENC;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				ST_ENC: begin
					if (enc_res.done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pending result kind
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			border_q <= !interior_s1;
			last_q   <= last_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (normals.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q   <= border_q ? CODE_MID : enc_res.x;
			out_y_q   <= border_q ? CODE_TOP : enc_res.y;
			out_z_q   <= border_q ? CODE_MID : enc_res.z;
			out_end_q <= last_q;
		end
	end

	assign normals.valid     = out_valid_q;
	assign normals.normal_x  = out_x_q;
	assign normals.normal_y  = out_y_q;
	assign normals.normal_z  = out_z_q;
	assign normals.frame_end = out_end_q;

`ifndef NO_ASSERTIONS
	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> state_q == ST_IDLE)
		else $error("item accepted outside idle");
	a_start_read: assert property (@(posedge clk) disable iff (!arst_n)
		enc_req.start |-> state_q == ST_READ && active_s1)
		else $error("encoder started without a sample");
	a_done_enc: assert property (@(posedge clk) disable iff (!arst_n)
		enc_res.done |-> state_q == ST_ENC)
		else $error("encoder finished while not waited on");
	a_end_border: assert property (@(posedge clk) disable iff (!arst_n)
		(normals.valid && normals.frame_end) |->
		(normals.normal_x == CODE_MID && normals.normal_y == CODE_TOP &&
		normals.normal_z == CODE_MID))
		else $error("last pixel of frame is not a border normal");
`endif
endmodule

// ===== tb/tb_height_to_normal_map_top.sv =====
`timescale 1ns / 1ps
module tb_height_to_normal_map_top;
	import hnm_pkg::*;

	localparam int LINE_MAX   = 1024;
	localparam int ROWS_MAX   = 4096;
	localparam int ITEM_GOAL  = 1150;
	localparam int SETTLE     = 80;
	localparam int STALL_CAP  = 5000;
	localparam int PART_CAP   = 120;

	typedef struct {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] z;
		logic       fe;
	} normal_t;

	typedef struct {
		logic       op;
		logic [7:0] raw;
		bit         typed;
		normal_t    res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	hnm_in_if  samples_if ();
	hnm_out_if normals_if ();
	hnm_cfg_if cfg_if ();

	height_to_normal_map_top #(
		.MAX_WIDTH(LINE_MAX),
		.MAX_ROWS (ROWS_MAX)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.normals(normals_if),
		.cfg    (cfg_if)
	);

	// shadow of the block's registers and state
	logic [10:0] pm_row_width;
	logic [12:0] pm_row_count;
	logic [7:0]  pm_max_height;
	logic [7:0]  pm_older [LINE_MAX];
	logic [7:0]  pm_newer [LINE_MAX];
	int          pm_col;
	int          pm_row;
	logic [7:0]  pm_taps [4];

	normal_t pending_normals [$];
	int      mismatches;
	int      items_sent;
	int      quiet_cycles = 0;
	bit      calm;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// true when (2k - 255) * sqrt(s) <= 255 * n
	function automatic bit code_fits(longint k, longint n, longint s);
		longint a;
		longint b;
		a = 2 * k - 255;
		b = 255 * n;
		if (a <= 0 && b >= 0) return 1'b1;
		if (a > 0 && b < 0) return 1'b0;
		if (a >= 0) return a * a * s <= b * b;
		return a * a * s >= b * b;
	endfunction

	// bisect for floor(127.5 * (1 + n / sqrt(s)))
	function automatic logic [7:0] encode_comp(longint n, longint s);
		longint lo;
		longint hi;
		longint mid;
		lo = 0;
		hi = 255;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (code_fits(mid, n, s)) lo = mid;
			else hi = mid - 1;
		end
		return lo[7:0];
	endfunction

	function automatic int clamp_size(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic shadow_reset();
		pm_row_width  = ROW_WIDTH_RST;
		pm_row_count  = ROW_COUNT_RST;
		pm_max_height = MAX_HEIGHT_RST;
		for (int i = 0; i < LINE_MAX; i++) begin
			pm_older[i] = '0;
			pm_newer[i] = '0;
		end
		pm_col = 0;
		pm_row = 0;
		for (int i = 0; i < 4; i++) pm_taps[i] = '0;
	endtask

	task automatic shadow_config(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
		if (idx == CFG_ROW_WIDTH) begin
			pm_row_width = val[10:0];
			pm_col = 0;
			pm_row = 0;
		end else if (idx == CFG_ROW_COUNT) begin
			pm_row_count = val[12:0];
			pm_col = 0;
			pm_row = 0;
		end else if (idx == CFG_MAX_HEIGHT) begin
			pm_max_height = val[7:0];
		end
	endtask

	// advance the shadow by one item; return 1 with the normal if one results
	function automatic bit predict_normal(logic op, logic [7:0] raw, output normal_t res);
		int w;
		int l;
		int c;
		int r;
		int hgt;
		int upv;
		int midv;
		int dx;
		int dy;
		bit interior;
		bit emit;
		bit last;
		longint s;
		w = clamp_size(int'(pm_row_width), 3, LINE_MAX);
		l = clamp_size(int'(pm_row_count), 3, ROWS_MAX);
		c = pm_col;
		r = pm_row;
		interior = 1'b0;
		last = 1'b0;
		dx = 0;
		dy = 0;
		res = '{8'd0, 8'd0, 8'd0, 1'b0};
		if (r < l) begin
			if (op) return 1'b0;
			hgt = (int'(raw) * int'(pm_max_height)) / 255;
			upv = int'(pm_older[c]);
			midv = int'(pm_newer[c]);
			pm_older[c] = midv[7:0];
			pm_newer[c] = hgt[7:0];
			if (c >= 2 && r >= 2) begin
				interior = 1'b1;
				dx = midv - int'(pm_taps[3]);
				dy = int'(pm_taps[0]) - int'(pm_taps[1]);
			end
			pm_taps[3] = pm_taps[2];
			pm_taps[2] = midv[7:0];
			pm_taps[0] = upv[7:0];
			pm_taps[1] = hgt[7:0];
		end
		emit = (r >= 2) || (r == 1 && c >= 1);
		last = (r >= l + 1) && (c == 0);
		c++;
		if (c >= w) begin
			c = 0;
			r++;
		end
		if (last) begin
			c = 0;
			r = 0;
		end
		pm_col = c;
		pm_row = r;
		if (!emit) return 1'b0;
		if (interior) begin
			s = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy) + 4;
			res.x = encode_comp(longint'(-dx), s);
			res.y = encode_comp(2, s);
			res.z = encode_comp(longint'(dy), s);
		end else begin
			res.x = CODE_MID;
			res.y = CODE_TOP;
			res.z = CODE_MID;
		end
		res.fe = last;
		return 1'b1;
	endfunction

	task automatic report(string what, int got, int want);
		$display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// drive one item with a random gap; queue its normal once accepted
	task automatic send_item(logic op, logic [7:0] raw, bit typed = 1'b0,
			normal_t typed_res = '{8'd0, 8'd0, 8'd0, 1'b0});
		normal_t res;
		if (!calm && $urandom_range(99) < 31) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		samples_if.valid      <= 1'b1;
		samples_if.operation  <= op;
		samples_if.raw_height <= raw;
		do @(posedge clk); while (!(samples_if.valid && samples_if.ready));
		if (predict_normal(op, raw, res))
			pending_normals.insert(pending_normals.size(), typed ? typed_res : res);
		items_sent++;
	endtask

	// hold valid until the register is taken; the caller drops it
	task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
		shadow_config(idx, val);
	endtask

	// wait for all normals, then let any work with no result finish
	task automatic drain_to_idle();
		samples_if.valid <= 1'b0;
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write all three registers in a random rotation
	task automatic set_frame(int w, int l, int mh);
		int first;
		first = $urandom_range(2);
		for (int i = 0; i < 3; i++) begin
			case ((first + i) % 3)
				0: write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(w));
				1: write_reg(CFG_ROW_COUNT, CFG_DATA_W'(l));
				default: write_reg(CFG_MAX_HEIGHT, CFG_DATA_W'(mh));
			endcase
		end
		cfg_if.valid <= 1'b0;
	endtask

	// one frame, well formed with drain noise, or cut short
	task automatic run_frame(bit broken);
		int w;
		int l;
		int n;
		int span;
		w = clamp_size(int'(pm_row_width), 3, LINE_MAX);
		l = clamp_size(int'(pm_row_count), 3, ROWS_MAX);
		if (broken) begin
			span = w * l + w;
			if (span > PART_CAP) span = PART_CAP;
			n = $urandom_range(1, span);
			for (int i = 0; i < n; i++)
				send_item($urandom_range(3) == 0, 8'($urandom_range(255)));
			return;
		end
		for (int i = 0; i < w * l; i++) begin
			if ($urandom_range(99) < 8) send_item(1'b1, 8'($urandom_range(255)));
			send_item(1'b0, 8'($urandom_range(255)));
		end
		for (int i = 0; i <= w; i++)
			send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
	endtask

	// normals sink: random stall and check against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		normal_t want;
		if (!arst_n) begin
			normals_if.ready <= 1'b0;
		end else begin
			normals_if.ready <= calm || ($urandom_range(99) >= 31);
			if (normals_if.valid && normals_if.ready) begin
				if (pending_normals.size() == 0) begin
					report("normal with none expected", int'(normals_if.normal_x), -1);
				end else begin
					want = pending_normals.pop_front();
					if (normals_if.normal_x !== want.x)
						report("normal_x", int'(normals_if.normal_x), int'(want.x));
					if (normals_if.normal_y !== want.y)
						report("normal_y", int'(normals_if.normal_y), int'(want.y));
					if (normals_if.normal_z !== want.z)
						report("normal_z", int'(normals_if.normal_z), int'(want.z));
					if (normals_if.frame_end !== want.fe)
						report("frame_end", int'(normals_if.frame_end), int'(want.fe));
				end
			end
		end
	end

	// watchdog on cycles with no item accepted anywhere
	always @(posedge clk) begin
		if ((samples_if.valid && samples_if.ready) || (normals_if.valid && normals_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_CAP) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		stim_row_t dir_rows [$];
		normal_t   flat;
		int        phase;
		int        w;
		int        l;
		int        mh;

		samples_if.valid      <= 1'b0;
		samples_if.operation  <= 1'b0;
		samples_if.raw_height <= '0;
		cfg_if.valid          <= 1'b0;
		cfg_if.index          <= CFG_ROW_WIDTH;
		cfg_if.data           <= '0;
		arst_n                <= 1'b0;
		mismatches   = 0;
		items_sent   = 0;
		calm         = 1'b0;
		shadow_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flat 3x3 frame: every normal is straight up, drain noise mid-frame
		flat = '{CODE_MID, CODE_TOP, CODE_MID, 1'b0};
		dir_rows = '{
			'{1'b0, 8'd0,   0, flat}, '{1'b0, 8'd255, 0, flat},
			'{1'b0, 8'd1,   0, flat}, '{1'b1, 8'd99,  0, flat},
			'{1'b0, 8'd200, 0, flat}, '{1'b0, 8'd77,  1, flat},
			'{1'b0, 8'd200, 1, flat}, '{1'b0, 8'd254, 1, flat},
			'{1'b0, 8'd255, 1, flat}, '{1'b0, 8'd0,   1, flat},
			'{1'b1, 8'd0,   1, flat}, '{1'b1, 8'd0,   1, flat},
			'{1'b1, 8'd0,   1, flat},
			'{1'b0, 8'd123, 1, '{CODE_MID, CODE_TOP, CODE_MID, 1'b1}},
			// steep center in both axes
			'{1'b0, 8'd0,   0, flat}, '{1'b0, 8'd0,   0, flat},
			'{1'b0, 8'd0,   0, flat}, '{1'b0, 8'd255, 0, flat},
			'{1'b0, 8'd9,   0, flat}, '{1'b0, 8'd0,   0, flat},
			'{1'b0, 8'd0,   0, flat}, '{1'b0, 8'd255, 0, flat},
			'{1'b0, 8'd0,   0, flat}, '{1'b1, 8'd0,   0, flat},
			'{1'b1, 8'd0,   0, flat}, '{1'b1, 8'd0,   0, flat},
			'{1'b1, 8'd0,   0, flat}
		};
		set_frame(3, 3, 255);
		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].raw, dir_rows[i].typed, dir_rows[i].res);
		drain_to_idle();

		// random frames
		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			calm = (phase >= 12 && phase < 18);
			w = ($urandom_range(99) < 6) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			l = ($urandom_range(99) < 6) ? $urandom_range(0, 2) : $urandom_range(3, 6);
			case ($urandom_range(9))
				0: mh = 0;
				1: mh = 255;
				default: mh = $urandom_range(255);
			endcase
			if (phase == 6) begin
				w = 2047;
				l = 3;
			end
			if (phase == 9) begin
				// huge row count: only a partial frame is run
				set_frame(w, 8191, mh);
				run_frame(1'b1);
			end else begin
				// chosen size: the oversized row width of phase 6 and about one frame in five at random are cut short
				set_frame(w, l, mh);
				run_frame(phase == 6 || $urandom_range(99) < 20);
			end
			drain_to_idle();
			phase++;
		end
		calm = 1'b0;

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
